// File: rtl/seg_pkg.sv
// shared constants for the segment intersection unit
package seg_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 32;
  // quotient bits kept by the dividers: enough to tell 2^31 from anything larger
  localparam int QUOT_BITS       = 33;

  localparam logic [1:0] REL_CROSS      = 2'd0;
  localparam logic [1:0] REL_PARALLEL   = 2'd1;
  localparam logic [1:0] REL_COLLINEAR  = 2'd2;
  localparam logic [1:0] REL_DEGENERATE = 2'd3;

  // places of the end point coordinates in a packed coordinate word
  localparam int AX1 = 0;
  localparam int AY1 = 1;
  localparam int AX2 = 2;
  localparam int AY2 = 3;
  localparam int BX1 = 4;
  localparam int BY1 = 5;
  localparam int BX2 = 6;
  localparam int BY2 = 7;

  // places of the direction components in a packed difference word
  localparam int DXA = 0;
  localparam int DYA = 1;
  localparam int DXB = 2;
  localparam int DYB = 3;

endpackage

// File: rtl/seg_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage, with overflow flag
module seg_div import seg_pkg::*; #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QB = QUOT_BITS,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          i_valid,
  input  logic [NW-1:0] i_num,
  input  logic [DW-1:0] i_den,
  input  logic [PW-1:0] i_pay,
  output logic          o_valid,
  output logic [QB-1:0] o_quot,
  output logic          o_ovf,
  output logic [PW-1:0] o_pay
);

  localparam int NE = (NW > QB) ? NW : QB + 1;
  localparam int TW = NE - QB;
  localparam int KW = (TW > DW) ? TW : DW;

  logic          v0_r;
  logic [NE-1:0] num0_r;
  logic [DW-1:0] den0_r;
  logic [PW-1:0] pay0_r;

  logic          v_r   [QB+1];
  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] low_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic [PW-1:0] pay_r [QB+1];
  logic          ovf_r [QB+1];

  logic [TW-1:0] top_nxt;
  assign top_nxt = num0_r[NE-1:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v_r[0]   <= 1'b0;
    end else begin
      v0_r     <= i_valid;
      v_r[0]   <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    num0_r   <= NE'(i_num);
    den0_r   <= i_den;
    pay0_r   <= i_pay;
    // quotient too large for the kept bits when the top part already reaches the divisor
    ovf_r[0] <= KW'(top_nxt) >= KW'(den0_r);
    rem_r[0] <= DW'(top_nxt);
    low_r[0] <= num0_r[QB-1:0];
    quo_r[0] <= '0;
    den_r[0] <= den0_r;
    pay_r[0] <= pay0_r;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] t_nxt;
    logic        ge_nxt;
    assign t_nxt  = {rem_r[k], low_r[k][QB-1]};
    assign ge_nxt = t_nxt >= (DW+1)'(den_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge_nxt ? DW'(t_nxt - (DW+1)'(den_r[k])) : DW'(t_nxt);
      low_r[k+1] <= {low_r[k][QB-2:0], 1'b0};
      quo_r[k+1] <= {quo_r[k][QB-2:0], ge_nxt};
      den_r[k+1] <= den_r[k];
      pay_r[k+1] <= pay_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  assign o_valid = v_r[QB];
  assign o_quot  = quo_r[QB];
  assign o_ovf   = ovf_r[QB];
  assign o_pay   = pay_r[QB];

endmodule

// File: rtl/segment_intersection_unit.sv
// segment intersection unit: line relation, crossing point and bounding box test
//
// One word of two segments enters per cycle and one result leaves per word, after passing
// through two bit-serial divider pipelines, one for the crossing x and one for the y value.
// busy is high only during reset and the cycle after it. Results appear with out_valid for one
// cycle and cannot be held off, so the receiver must take each word when it comes.
module segment_intersection_unit import seg_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_a_x1,
  input  logic signed [COORD_WIDTH-1:0] in_a_y1,
  input  logic signed [COORD_WIDTH-1:0] in_a_x2,
  input  logic signed [COORD_WIDTH-1:0] in_a_y2,
  input  logic signed [COORD_WIDTH-1:0] in_b_x1,
  input  logic signed [COORD_WIDTH-1:0] in_b_y1,
  input  logic signed [COORD_WIDTH-1:0] in_b_x2,
  input  logic signed [COORD_WIDTH-1:0] in_b_y2,
  output logic                          out_valid,
  output logic [1:0]                    out_relation,
  output logic signed [OUT_WIDTH-1:0]   out_cross_x,
  output logic signed [OUT_WIDTH-1:0]   out_cross_y,
  output logic                          out_in_segments,
  output logic                          out_saturated
);

  localparam int CW    = COORD_WIDTH;
  localparam int D     = CW + 1;
  localparam int PDW   = 2 * D;
  localparam int PAW   = D + CW;
  localparam int DETW  = 2 * D + 1;
  localparam int CAW   = D + CW + 1;
  localparam int MW    = CAW + D;
  localparam int NUMW  = MW + 1;
  localparam int XNW   = NUMW + 1;
  localparam int XDW   = DETW + 1;
  localparam int OW    = OUT_WIDTH;
  localparam int XDIFW = OW + 2;
  localparam int YPW   = CW + D;
  localparam int YDW   = D + XDIFW;
  localparam int YNW   = YDW + 1;
  localparam int QB    = QUOT_BITS;
  localparam int XPLW  = 5 + 4 * D + 8 * CW;
  localparam int YPLW  = 4 + OW + 8 * CW;
  localparam int DIV_LAT = QB + 2;
  localparam int LAT   = 2 * DIV_LAT + 14;

  typedef logic [7:0][CW-1:0] crd_t;
  typedef logic [3:0][D-1:0]  dif_t;

  function automatic logic betw(input logic signed [OW+1:0] v,
                                input logic signed [OW+1:0] e1,
                                input logic signed [OW+1:0] e2);
    return (v >= e1 && v <= e2) || (v >= e2 && v <= e1);
  endfunction

  logic busy_r;

  // stage a: input word
  logic va_r;
  crd_t crd_a_r;
  // stage b: differences
  logic vb_r;
  crd_t crd_b_r;
  dif_t dif_b_r;
  logic signed [D-1:0] eya_r, exa_r;
  // stage c: products
  logic vc_r;
  crd_t crd_c_r;
  dif_t dif_c_r;
  logic degen_c_r, verta_c_r, vertb_c_r;
  logic signed [PDW-1:0] pd1_r, pd2_r, pc1_r, pc2_r;
  logic signed [PAW-1:0] pa1_r, pa2_r, pb1_r, pb2_r;
  // stage d: determinant and line constants
  logic vd_r;
  crd_t crd_d_r;
  dif_t dif_d_r;
  logic degen_d_r, verta_d_r, vertb_d_r;
  logic signed [DETW-1:0] det_d_r, cr_r;
  logic signed [CAW-1:0]  ca_r, cb_r;
  // stage e: numerator products and relation
  logic ve_r;
  crd_t crd_e_r;
  dif_t dif_e_r;
  logic verta_e_r, vertb_e_r;
  logic [1:0] rel_e_r;
  logic signed [DETW-1:0] det_e_r;
  logic signed [MW-1:0]   m1_r, m2_r;
  // stage f: numerator
  logic vf_r;
  crd_t crd_f_r;
  dif_t dif_f_r;
  logic verta_f_r, vertb_f_r;
  logic [1:0] rel_f_r;
  logic signed [DETW-1:0] det_f_r;
  logic signed [NUMW-1:0] num_r;
  // stage g: magnitudes
  logic vg_r;
  crd_t crd_g_r;
  dif_t dif_g_r;
  logic verta_g_r, vertb_g_r, negx_g_r;
  logic [1:0] rel_g_r;
  logic [NUMW-1:0] nabs_r;
  logic [DETW-1:0] dabs_r;

  // x divider
  logic [XNW-1:0]  xnum_nxt;
  logic [XDW-1:0]  xden_nxt;
  logic [XPLW-1:0] xpay_nxt, xpay_o;
  logic            xv_o, xovf_o;
  logic [QB-1:0]   xq_o;
  logic [1:0]      rel_x;
  logic            verta_x, vertb_x, negx_x;
  dif_t            dif_x;
  crd_t            crd_x;

  // stage i: crossing x and the line for y
  logic vi_r;
  crd_t crd_i_r;
  logic [1:0] rel_i_r;
  logic satx_i_r;
  logic signed [OW-1:0] x_i_r;
  logic signed [CW-1:0] lx1_r, ly1_i_r;
  logic signed [D-1:0]  ldx_i_r, ldy_i_r;
  // stage j
  logic vj_r;
  crd_t crd_j_r;
  logic [1:0] rel_j_r;
  logic satx_j_r;
  logic signed [OW-1:0] x_j_r;
  logic signed [CW-1:0] ly1_j_r;
  logic signed [D-1:0]  ldx_j_r, ldy_j_r;
  logic signed [XDIFW-1:0] xd_r;
  // stage k
  logic vk_r;
  crd_t crd_k_r;
  logic [1:0] rel_k_r;
  logic satx_k_r;
  logic signed [OW-1:0] x_k_r;
  logic signed [D-1:0]  ldx_k_r;
  logic signed [YPW-1:0] py_r;
  logic signed [YDW-1:0] pdy_r;
  // stage l
  logic vl_r;
  crd_t crd_l_r;
  logic [1:0] rel_l_r;
  logic satx_l_r;
  logic signed [OW-1:0] x_l_r;
  logic signed [D-1:0]  ldx_l_r;
  logic signed [YNW-1:0] ny_r;
  // stage m
  logic vm_r;
  crd_t crd_m_r;
  logic [1:0] rel_m_r;
  logic satx_m_r, negy_m_r;
  logic signed [OW-1:0] x_m_r;
  logic [YNW-1:0] nyabs_r;
  logic [D-1:0]   dxabs_r;

  // y divider
  logic [YPLW-1:0] ypay_nxt, ypay_o;
  logic            yv_o, yovf_o;
  logic [QB-1:0]   yq_o;
  logic [1:0]      rel_y;
  logic            satx_y, negy_y;
  logic [OW-1:0]   x_y;
  crd_t            crd_y;

  // stage n: y value
  logic vn_r;
  crd_t crd_n_r;
  logic [1:0] rel_n_r;
  logic sat_n_r;
  logic signed [OW-1:0] x_n_r, y_n_r;

  // output word
  logic out_valid_r, out_in_segments_r, out_saturated_r;
  logic [1:0] out_relation_r;
  logic signed [OW-1:0] out_cross_x_r, out_cross_y_r;

  // combinational pieces
  logic [QB-1:0] limx_nxt, qsx_nxt, qnx_nxt, limy_nxt, qsy_nxt, qny_nxt;
  logic          satx_nxt, saty_nxt;
  logic signed [OW+1:0] bx_nxt, by_nxt;
  logic          inside_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      vg_r        <= 1'b0;
      vi_r        <= 1'b0;
      vj_r        <= 1'b0;
      vk_r        <= 1'b0;
      vl_r        <= 1'b0;
      vm_r        <= 1'b0;
      vn_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      va_r        <= start && !busy_r;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      vd_r        <= vc_r;
      ve_r        <= vd_r;
      vf_r        <= ve_r;
      vg_r        <= vf_r;
      vi_r        <= xv_o;
      vj_r        <= vi_r;
      vk_r        <= vj_r;
      vl_r        <= vk_r;
      vm_r        <= vl_r;
      vn_r        <= yv_o;
      out_valid_r <= vn_r;
    end
  end

  // front end up to the x divider
  always_ff @(posedge clk) begin
    crd_a_r <= {in_b_y2, in_b_x2, in_b_y1, in_b_x1, in_a_y2, in_a_x2, in_a_y1, in_a_x1};

    crd_b_r       <= crd_a_r;
    dif_b_r[DXA]  <= D'(signed'(crd_a_r[AX2])) - D'(signed'(crd_a_r[AX1]));
    dif_b_r[DYA]  <= D'(signed'(crd_a_r[AY2])) - D'(signed'(crd_a_r[AY1]));
    dif_b_r[DXB]  <= D'(signed'(crd_a_r[BX2])) - D'(signed'(crd_a_r[BX1]));
    dif_b_r[DYB]  <= D'(signed'(crd_a_r[BY2])) - D'(signed'(crd_a_r[BY1]));
    eya_r         <= D'(signed'(crd_a_r[BY1])) - D'(signed'(crd_a_r[AY1]));
    exa_r         <= D'(signed'(crd_a_r[BX1])) - D'(signed'(crd_a_r[AX1]));

    crd_c_r   <= crd_b_r;
    dif_c_r   <= dif_b_r;
    degen_c_r <= (dif_b_r[DXA] == '0 && dif_b_r[DYA] == '0) ||
                 (dif_b_r[DXB] == '0 && dif_b_r[DYB] == '0);
    verta_c_r <= dif_b_r[DXA] == '0;
    vertb_c_r <= dif_b_r[DXB] == '0;
    pd1_r <= PDW'(signed'(dif_b_r[DXA])) * PDW'(signed'(dif_b_r[DYB]));
    pd2_r <= PDW'(signed'(dif_b_r[DYA])) * PDW'(signed'(dif_b_r[DXB]));
    pc1_r <= PDW'(signed'(dif_b_r[DXA])) * PDW'(eya_r);
    pc2_r <= PDW'(signed'(dif_b_r[DYA])) * PDW'(exa_r);
    pa1_r <= PAW'(signed'(dif_b_r[DYA])) * PAW'(signed'(crd_b_r[AX1]));
    pa2_r <= PAW'(signed'(dif_b_r[DXA])) * PAW'(signed'(crd_b_r[AY1]));
    pb1_r <= PAW'(signed'(dif_b_r[DYB])) * PAW'(signed'(crd_b_r[BX1]));
    pb2_r <= PAW'(signed'(dif_b_r[DXB])) * PAW'(signed'(crd_b_r[BY1]));

    crd_d_r   <= crd_c_r;
    dif_d_r   <= dif_c_r;
    degen_d_r <= degen_c_r;
    verta_d_r <= verta_c_r;
    vertb_d_r <= vertb_c_r;
    det_d_r   <= DETW'(pd1_r) - DETW'(pd2_r);
    cr_r      <= DETW'(pc1_r) - DETW'(pc2_r);
    ca_r      <= CAW'(pa1_r) - CAW'(pa2_r);
    cb_r      <= CAW'(pb1_r) - CAW'(pb2_r);

    crd_e_r   <= crd_d_r;
    dif_e_r   <= dif_d_r;
    verta_e_r <= verta_d_r;
    vertb_e_r <= vertb_d_r;
    det_e_r   <= det_d_r;
    if (degen_d_r) begin
      rel_e_r <= REL_DEGENERATE;
    end else if (det_d_r == '0) begin
      rel_e_r <= (cr_r == '0) ? REL_COLLINEAR : REL_PARALLEL;
    end else begin
      rel_e_r <= REL_CROSS;
    end
    m1_r <= MW'(cb_r) * MW'(signed'(dif_d_r[DXA]));
    m2_r <= MW'(ca_r) * MW'(signed'(dif_d_r[DXB]));

    crd_f_r   <= crd_e_r;
    dif_f_r   <= dif_e_r;
    verta_f_r <= verta_e_r;
    vertb_f_r <= vertb_e_r;
    rel_f_r   <= rel_e_r;
    det_f_r   <= det_e_r;
    num_r     <= NUMW'(m1_r) - NUMW'(m2_r);

    crd_g_r   <= crd_f_r;
    dif_g_r   <= dif_f_r;
    verta_g_r <= verta_f_r;
    vertb_g_r <= vertb_f_r;
    rel_g_r   <= rel_f_r;
    negx_g_r  <= num_r[NUMW-1] ^ det_f_r[DETW-1];
    nabs_r    <= num_r[NUMW-1] ? NUMW'(-num_r) : NUMW'(num_r);
    dabs_r    <= det_f_r[DETW-1] ? DETW'(-det_f_r) : DETW'(det_f_r);
  end

  // rounding half away from zero: (2|num| + |det|) / (2|det|)
  assign xnum_nxt = XNW'({nabs_r, 1'b0}) + XNW'(dabs_r);
  assign xden_nxt = {dabs_r, 1'b0};
  assign xpay_nxt = {rel_g_r, verta_g_r, vertb_g_r, negx_g_r, dif_g_r, crd_g_r};

  seg_div #(
    .NW(XNW),
    .DW(XDW),
    .QB(QB),
    .PW(XPLW)
  ) u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_valid(vg_r),
    .i_num  (xnum_nxt),
    .i_den  (xden_nxt),
    .i_pay  (xpay_nxt),
    .o_valid(xv_o),
    .o_quot (xq_o),
    .o_ovf  (xovf_o),
    .o_pay  (xpay_o)
  );

  assign {rel_x, verta_x, vertb_x, negx_x, dif_x, crd_x} = xpay_o;

  always_comb begin
    limx_nxt = QB'(32'h7FFF_FFFF) + QB'(negx_x);
    satx_nxt = xovf_o || (xq_o > limx_nxt);
    qsx_nxt  = satx_nxt ? limx_nxt : xq_o;
    qnx_nxt  = negx_x ? QB'(~qsx_nxt + QB'(1)) : qsx_nxt;
  end

  // back end: y on one of the lines
  always_ff @(posedge clk) begin
    crd_i_r <= crd_x;
    rel_i_r <= rel_x;
    if (verta_x) begin
      x_i_r    <= OW'(signed'(crd_x[AX1]));
      satx_i_r <= 1'b0;
      lx1_r    <= signed'(crd_x[BX1]);
      ly1_i_r  <= signed'(crd_x[BY1]);
      ldx_i_r  <= signed'(dif_x[DXB]);
      ldy_i_r  <= signed'(dif_x[DYB]);
    end else begin
      if (vertb_x) begin
        x_i_r    <= OW'(signed'(crd_x[BX1]));
        satx_i_r <= 1'b0;
      end else begin
        x_i_r    <= signed'(OW'(qnx_nxt));
        satx_i_r <= satx_nxt;
      end
      lx1_r   <= signed'(crd_x[AX1]);
      ly1_i_r <= signed'(crd_x[AY1]);
      ldx_i_r <= signed'(dif_x[DXA]);
      ldy_i_r <= signed'(dif_x[DYA]);
    end

    crd_j_r  <= crd_i_r;
    rel_j_r  <= rel_i_r;
    satx_j_r <= satx_i_r;
    x_j_r    <= x_i_r;
    ly1_j_r  <= ly1_i_r;
    ldx_j_r  <= ldx_i_r;
    ldy_j_r  <= ldy_i_r;
    xd_r     <= XDIFW'(x_i_r) - XDIFW'(lx1_r);

    crd_k_r  <= crd_j_r;
    rel_k_r  <= rel_j_r;
    satx_k_r <= satx_j_r;
    x_k_r    <= x_j_r;
    ldx_k_r  <= ldx_j_r;
    py_r     <= YPW'(ly1_j_r) * YPW'(ldx_j_r);
    pdy_r    <= YDW'(ldy_j_r) * YDW'(xd_r);

    crd_l_r  <= crd_k_r;
    rel_l_r  <= rel_k_r;
    satx_l_r <= satx_k_r;
    x_l_r    <= x_k_r;
    ldx_l_r  <= ldx_k_r;
    ny_r     <= YNW'(py_r) + YNW'(pdy_r);

    crd_m_r  <= crd_l_r;
    rel_m_r  <= rel_l_r;
    satx_m_r <= satx_l_r;
    x_m_r    <= x_l_r;
    negy_m_r <= ny_r[YNW-1] ^ ldx_l_r[D-1];
    nyabs_r  <= ny_r[YNW-1] ? YNW'(-ny_r) : YNW'(ny_r);
    dxabs_r  <= ldx_l_r[D-1] ? D'(-ldx_l_r) : D'(ldx_l_r);
  end

  assign ypay_nxt = {rel_m_r, satx_m_r, negy_m_r, x_m_r, crd_m_r};

  seg_div #(
    .NW(YNW),
    .DW(D),
    .QB(QB),
    .PW(YPLW)
  ) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_valid(vm_r),
    .i_num  (nyabs_r),
    .i_den  (dxabs_r),
    .i_pay  (ypay_nxt),
    .o_valid(yv_o),
    .o_quot (yq_o),
    .o_ovf  (yovf_o),
    .o_pay  (ypay_o)
  );

  assign {rel_y, satx_y, negy_y, x_y, crd_y} = ypay_o;

  always_comb begin
    limy_nxt = QB'(32'h7FFF_FFFF) + QB'(negy_y);
    saty_nxt = yovf_o || (yq_o > limy_nxt);
    qsy_nxt  = saty_nxt ? limy_nxt : yq_o;
    qny_nxt  = negy_y ? QB'(~qsy_nxt + QB'(1)) : qsy_nxt;
  end

  always_ff @(posedge clk) begin
    crd_n_r <= crd_y;
    rel_n_r <= rel_y;
    x_n_r   <= signed'(x_y);
    y_n_r   <= signed'(OW'(qny_nxt));
    sat_n_r <= satx_y || saty_nxt;
  end

  always_comb begin
    bx_nxt = (OW+2)'(x_n_r);
    by_nxt = (OW+2)'(y_n_r);
    inside_nxt = betw(bx_nxt, (OW+2)'(signed'(crd_n_r[AX1])), (OW+2)'(signed'(crd_n_r[AX2]))) &&
                 betw(by_nxt, (OW+2)'(signed'(crd_n_r[AY1])), (OW+2)'(signed'(crd_n_r[AY2]))) &&
                 betw(bx_nxt, (OW+2)'(signed'(crd_n_r[BX1])), (OW+2)'(signed'(crd_n_r[BX2]))) &&
                 betw(by_nxt, (OW+2)'(signed'(crd_n_r[BY1])), (OW+2)'(signed'(crd_n_r[BY2])));
  end

  // everything but the relation reads zero unless the lines cross
  always_ff @(posedge clk) begin
    out_relation_r <= rel_n_r;
    if (rel_n_r == REL_CROSS) begin
      out_cross_x_r     <= x_n_r;
      out_cross_y_r     <= y_n_r;
      out_in_segments_r <= inside_nxt;
      out_saturated_r   <= sat_n_r;
    end else begin
      out_cross_x_r     <= '0;
      out_cross_y_r     <= '0;
      out_in_segments_r <= 1'b0;
      out_saturated_r   <= 1'b0;
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_relation    = out_relation_r;
  assign out_cross_x     = out_cross_x_r;
  assign out_cross_y     = out_cross_y_r;
  assign out_in_segments = out_in_segments_r;
  assign out_saturated   = out_saturated_r;

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted word did not come out after the pipeline latency");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word with no matching accepted word");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_relation != REL_CROSS) |->
      (out_cross_x == '0 && out_cross_y == '0 && !out_in_segments && !out_saturated))
    else $error("point fields set for lines that do not cross");

endmodule
